// ===== design/tbm_pkg.sv =====
// Package for the TLSF bin bitmap manager: default sizes, operation codes,
// controller command and status structs, and bit-search helpers.
// Used by tbm_ctrl, tbm_datapath and tlsf_bin_bitmap_manager_core.
package tbm_pkg;

  localparam int SECOND_LEVEL_BITS = 4;
  localparam int FIRST_LEVEL_COUNT = 32;
  localparam int COUNT_WIDTH       = 16;

  localparam int OP_WIDTH   = 2;
  localparam int SIZE_WIDTH = 32;
  localparam int FL_FIELD_W = 5;
  localparam int SL_FIELD_W = 4;

  localparam logic [OP_WIDTH-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_REMOVE  = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_SEARCH  = 2'd2;
  localparam logic [OP_WIDTH-1:0] OP_UNKNOWN = 2'd3;

  // Commands from the sequencer to the datapath, one step each.
  typedef struct packed {
    logic clear_step;
    logic load;
    logic find_msb;
    logic map;
    logic rd_bin;
    logic exec;
    logic rd_next;
    logic finish_next;
  } tbm_cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic clear_last;
    logic need_next;
    logic out_busy;
  } tbm_status_t;

  // Index of the highest set bit of a 32-bit word (0 when the word is 0).
  function automatic logic [4:0] msb32(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  // Index of the lowest set bit of a 64-bit word (0 when the word is 0).
  function automatic logic [5:0] lsb64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

// ===== design/tbm_ctrl.sv =====
// Sequencer for the TLSF bin bitmap manager: clearing sweep, then one item
// at a time through leading-one, map, read, execute and an optional second
// bitmap read. Depends on tbm_pkg for the command and status structs.
module tbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tbm_pkg::tbm_status_t status,
  output tbm_pkg::tbm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MSB,
    ST_MAP,
    ST_READ,
    ST_EXEC,
    ST_READ2,
    ST_FIND2
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MSB;
        end
      end
      ST_MSB: begin
        cmd.find_msb = 1'b1;
        state_next   = ST_MAP;
      end
      ST_MAP: begin
        cmd.map    = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd_bin = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold while the previous result is still stalled
        if (!status.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = status.need_next ? ST_READ2 : ST_IDLE;
        end
      end
      ST_READ2: begin
        cmd.rd_next = 1'b1;
        state_next  = ST_FIND2;
      end
      ST_FIND2: begin
        if (!status.out_busy) begin
          cmd.finish_next = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

// ===== design/tbm_datapath.sv =====
// Datapath of the TLSF bin bitmap manager: size mapping, bin count memory,
// second-level bitmap rows, first-level bitmap and the output register.
// Depends on tbm_pkg; driven by tbm_ctrl commands.
module tbm_datapath #(
  parameter int SECOND_LEVEL_BITS = tbm_pkg::SECOND_LEVEL_BITS,
  parameter int FIRST_LEVEL_COUNT = tbm_pkg::FIRST_LEVEL_COUNT,
  parameter int COUNT_WIDTH       = tbm_pkg::COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tbm_pkg::tbm_cmd_t               cmd,
  output tbm_pkg::tbm_status_t            status,
  input  logic [tbm_pkg::OP_WIDTH-1:0]    operation,
  input  logic [tbm_pkg::SIZE_WIDTH-1:0]  size_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [tbm_pkg::FL_FIELD_W-1:0]  first_level,
  output logic [tbm_pkg::SL_FIELD_W-1:0]  second_level,
  output logic                            error
);

  localparam int SLB   = SECOND_LEVEL_BITS;
  localparam int SLC   = 1 << SECOND_LEVEL_BITS;
  localparam int FLC   = FIRST_LEVEL_COUNT;
  localparam int FLW   = $clog2(FIRST_LEVEL_COUNT);
  localparam int BINS  = FIRST_LEVEL_COUNT * SLC;
  localparam int BIN_W = FLW + SLB;
  localparam int SW    = tbm_pkg::SIZE_WIDTH;

  // Item registers
  logic [tbm_pkg::OP_WIDTH-1:0] op_q;
  logic [SW-1:0]                size_q;
  logic                         small_q;
  logic [4:0]                   msb_q;
  logic [FLW-1:0]               fl_q;
  logic [SLB-1:0]               sl_q;
  logic [FLW-1:0]               nf_q;
  logic [COUNT_WIDTH-1:0]       cnt_rd;
  logic [SLC-1:0]               row_rd;

  // Bookkeeping state
  logic [FLC-1:0]               l1;
  logic [SLC-1:0]               l2 [FLC];
  logic [COUNT_WIDTH-1:0]       cnt_mem [BINS];
  logic [BIN_W-1:0]             clr_addr;

  // Size mapping
  logic [4:0]       shift;
  logic [SW-1:0]    shifted;
  logic [SW-1:0]    low_mask;
  logic             rem;
  logic [SLB-1:0]   s_base;
  logic [SLB:0]     s_inc;
  logic [FLW-1:0]   fl_map;
  logic [SLB-1:0]   sl_map;

  always_comb begin
    shift    = msb_q - 5'(SLB);
    shifted  = size_q >> shift;
    low_mask = ~({SW{1'b1}} << shift);
    rem      = |(size_q & low_mask);
    s_base   = shifted[SLB-1:0];
    s_inc    = {1'b0, s_base} + (SLB+1)'(1);
    fl_map   = FLW'(msb_q);
    sl_map   = s_base;
    if (small_q) begin
      fl_map = '0;
      sl_map = size_q[SLB-1:0];
    end else if (7'(msb_q) >= 7'(FLC)) begin
      fl_map = FLW'(FLC - 1);
      sl_map = '1;
    end else if (op_q == tbm_pkg::OP_SEARCH && rem) begin
      if (s_inc[SLB]) begin
        if (7'(msb_q) + 7'd1 < 7'(FLC)) begin
          fl_map = FLW'(msb_q) + FLW'(1);
          sl_map = '0;
        end else begin
          sl_map = '1;
        end
      end else begin
        sl_map = s_inc[SLB-1:0];
      end
    end
  end

  // Execute step
  logic [BIN_W-1:0]       bin_idx;
  logic [SLC-1:0]         sl_bit;
  logic [FLC-1:0]         fl_bit;
  logic                   cnt_full;
  logic                   cnt_empty;
  logic [SLC-1:0]         row_cleared;
  logic [SLC-1:0]         row_hit;
  logic [FLC-1:0]         above;
  logic                   has_above;
  logic                   need_next;
  logic                   exec_err;
  logic                   cnt_we;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   emit;
  logic                   res_found;
  logic [FLW-1:0]         res_fl;
  logic [SLB-1:0]         res_sl;
  logic                   next_found;

  always_comb begin
    bin_idx     = {fl_q, sl_q};
    sl_bit      = SLC'(1) << sl_q;
    fl_bit      = FLC'(1) << fl_q;
    cnt_full    = (cnt_rd == {COUNT_WIDTH{1'b1}});
    cnt_empty   = (cnt_rd == '0);
    row_cleared = row_rd & ~sl_bit;
    row_hit     = row_rd & ({SLC{1'b1}} << sl_q);
    above       = ({FLC{1'b1}} << fl_q) << 1;
    has_above   = (7'(fl_q) + 7'd1 < 7'(FLC)) && ((l1 & above) != '0);
    need_next   = (op_q == tbm_pkg::OP_SEARCH) && (row_hit == '0) && has_above;
    exec_err    = 1'b0;
    cnt_we      = 1'b0;
    cnt_new     = cnt_rd;
    res_found   = 1'b0;
    res_fl      = fl_q;
    res_sl      = sl_q;
    case (op_q)
      tbm_pkg::OP_INSERT: begin
        exec_err = cnt_full;
        cnt_we   = !cnt_full;
        cnt_new  = cnt_rd + COUNT_WIDTH'(1);
      end
      tbm_pkg::OP_REMOVE: begin
        exec_err = cnt_empty;
        cnt_we   = !cnt_empty;
        cnt_new  = cnt_rd - COUNT_WIDTH'(1);
      end
      tbm_pkg::OP_SEARCH: begin
        if (row_hit != '0) begin
          res_found = 1'b1;
          res_sl    = SLB'(tbm_pkg::lsb64(64'(row_hit)));
        end
      end
      default: begin
        exec_err = 1'b1;
        res_fl   = '0;
        res_sl   = '0;
      end
    endcase
    next_found = (row_rd != '0);
    emit       = (cmd.exec && !need_next) || cmd.finish_next;
  end

  assign status.need_next  = need_next;
  assign status.clear_last = (clr_addr == BIN_W'(BINS - 1));
  assign status.out_busy   = out_valid && out_stall;

  // Item capture, mapping and reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      size_q <= size_bytes;
    end
    if (cmd.find_msb) begin
      msb_q   <= tbm_pkg::msb32(size_q);
      small_q <= (size_q < SW'(SLC));
    end
    if (cmd.map) begin
      fl_q <= fl_map;
      sl_q <= sl_map;
    end
    if (cmd.rd_bin) begin
      cnt_rd <= cnt_mem[bin_idx];
      row_rd <= l2[fl_q];
    end else if (cmd.rd_next) begin
      row_rd <= l2[nf_q];
    end
    if (cmd.exec && need_next) begin
      nf_q <= FLW'(tbm_pkg::lsb64(64'(l1 & above)));
    end
  end

  // Bin count memory: clearing sweep after reset, then read-modify-write
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      cnt_mem[clr_addr] <= '0;
    end else if (cmd.exec && cnt_we) begin
      cnt_mem[bin_idx] <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + BIN_W'(1);
    end
  end

  // Bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      l1 <= '0;
      for (int i = 0; i < FLC; i++) l2[i] <= '0;
    end else if (cmd.exec && cnt_we) begin
      if (op_q == tbm_pkg::OP_INSERT) begin
        l2[fl_q] <= row_rd | sl_bit;
        l1       <= l1 | fl_bit;
      end else if (cnt_rd == COUNT_WIDTH'(1)) begin
        // bin drains: drop its bit, and the row bit once the row is empty
        l2[fl_q] <= row_cleared;
        if (row_cleared == '0) l1 <= l1 & ~fl_bit;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_next) begin
      found        <= next_found;
      first_level  <= tbm_pkg::FL_FIELD_W'(next_found ? nf_q : fl_q);
      second_level <= tbm_pkg::SL_FIELD_W'(next_found ?
                        SLB'(tbm_pkg::lsb64(64'(row_rd))) : sl_q);
      error        <= 1'b0;
    end else if (emit) begin
      found        <= res_found;
      first_level  <= tbm_pkg::FL_FIELD_W'(res_fl);
      second_level <= tbm_pkg::SL_FIELD_W'(res_sl);
      error        <= exec_err;
    end
  end

  a_no_emit_over_stalled: assert property (@(posedge clk) disable iff (rst)
    !(emit && out_valid && out_stall))
    else $error("result written over a stalled transfer");

  a_insert_sets_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && op_q == tbm_pkg::OP_INSERT && !cnt_full) |=> ((l1 & $past(fl_bit)) != '0))
    else $error("insert left first-level bit clear");

  a_found_no_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> !error)
    else $error("search result flags error");

  a_clear_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !(cmd.exec || cmd.load))
    else $error("item work during clearing sweep");

endmodule

// ===== design/tlsf_bin_bitmap_manager_core.sv =====
// TLSF bin bitmap manager, top level: tbm_ctrl sequencer plus tbm_datapath.
// Each item passes MSB, MAP, READ and EXEC after the input transfer, and EXEC
// registers the result; a search moving to a higher first level adds READ2 and
// FIND2. New items wait until the last one's serial map, count-memory read and
// write steps are done. Reset: synchronous; then in_stall is high for a sweep of
// FIRST_LEVEL_COUNT * 2**SECOND_LEVEL_BITS count bins (512 by default), clearing each.
module tlsf_bin_bitmap_manager_core #(
  parameter int SECOND_LEVEL_BITS = tbm_pkg::SECOND_LEVEL_BITS,
  parameter int FIRST_LEVEL_COUNT = tbm_pkg::FIRST_LEVEL_COUNT,
  parameter int COUNT_WIDTH       = tbm_pkg::COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tbm_pkg::OP_WIDTH-1:0]    operation,
  input  logic [tbm_pkg::SIZE_WIDTH-1:0]  size_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [tbm_pkg::FL_FIELD_W-1:0]  first_level,
  output logic [tbm_pkg::SL_FIELD_W-1:0]  second_level,
  output logic                            error
);

  tbm_pkg::tbm_cmd_t    cmd;
  tbm_pkg::tbm_status_t status;

  tbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tbm_datapath #(
    .SECOND_LEVEL_BITS (SECOND_LEVEL_BITS),
    .FIRST_LEVEL_COUNT (FIRST_LEVEL_COUNT),
    .COUNT_WIDTH       (COUNT_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .size_bytes   (size_bytes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .first_level  (first_level),
    .second_level (second_level),
    .error        (error)
  );

endmodule
